// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers, included by code_symbol_bit_packer.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// check prop at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== design/csbp_pkg.sv =====
// ----------------------------------------------------------------------------
// csbp_pkg
// Types and constants of the code/symbol bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package csbp_pkg;

  localparam int SYMBOL_WIDTH = 8;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = 7;
  localparam int PCNT_W       = 3;

  typedef enum logic {
    CMD_PACK  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/csbp_front.sv =====
// ----------------------------------------------------------------------------
// csbp_front
// Accepts requests, merges code and symbol bits with the pending bits and
// queues a job of whole bytes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_front
  import csbp_pkg::*;
#(
  parameter int CODE_WIDTH = 16,
  parameter int ACC_W      = PEND_W + CODE_WIDTH + SYMBOL_WIDTH,
  parameter int NB_W       = $clog2(ACC_W / BYTE_W + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_command,
  input  wire logic [CODE_WIDTH-1:0]   in_code,
  input  wire logic [SYMBOL_WIDTH-1:0] in_symbol,
  input  wire logic [4:0]              in_code_length,
  input  wire logic                    q_full,
  output logic                         q_push,
  output logic [ACC_W-1:0]             job_acc,
  output logic [NB_W-1:0]              job_nbytes
);

  logic [PEND_W-1:0]     pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0]     pend_cnt_r, pend_cnt_nxt;
  logic                  accept;
  logic                  is_flush;
  logic [5:0]            len_ext;
  logic [5:0]            len;
  logic [5:0]            sym_sh;
  logic [6:0]            total;
  logic [CODE_WIDTH-1:0] code_mask;
  logic [ACC_W-1:0]      pack_acc;
  logic [NB_W-1:0]       pack_nbytes;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_flush = (cmd_t'(in_command) == CMD_FLUSH);

  always_comb begin
    len_ext     = {1'b0, in_code_length};
    len         = (len_ext > 6'(CODE_WIDTH)) ? 6'(CODE_WIDTH) : len_ext;
    code_mask   = ~({CODE_WIDTH{1'b1}} << len);
    sym_sh      = len + 6'(pend_cnt_r);
    pack_acc    = ACC_W'(pend_bits_r)
                | (ACC_W'(in_code & code_mask) << pend_cnt_r)
                | (ACC_W'(in_symbol) << sym_sh);
    total       = 7'(sym_sh) + 7'(SYMBOL_WIDTH);
    pack_nbytes = NB_W'(total >> 3);
  end

  always_comb begin
    q_push        = 1'b0;
    job_acc       = pack_acc;
    job_nbytes    = pack_nbytes;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (accept) begin
      if (is_flush) begin
        q_push        = (pend_cnt_r != '0);
        job_acc       = ACC_W'(pend_bits_r);
        job_nbytes    = NB_W'(1);
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end else begin
        q_push        = 1'b1;
        pend_cnt_nxt  = total[2:0];
        pend_bits_nxt = PEND_W'(pack_acc >> {pack_nbytes, 3'b000});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/csbp_queue.sv =====
// ----------------------------------------------------------------------------
// csbp_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_queue
  import csbp_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output q_status_t             status
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign status.count = count_r;
  assign rd_data      = mem_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/csbp_back.sv =====
// ----------------------------------------------------------------------------
// csbp_back
// Emits the bytes of the head job, one per cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csbp_back
  import csbp_pkg::*;
#(
  parameter int ACC_W = 31,
  parameter int NB_W  = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ACC_W-1:0]  job_acc,
  input  wire logic [NB_W-1:0]   job_nbytes,
  input  wire q_status_t         q_status,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_out_byte,
  output logic                   out_last
);

  logic [NB_W-1:0]   idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              load;
  logic              is_last;

  assign out_valid    = valid_r;
  assign out_out_byte = byte_r;
  assign out_last     = last_r;
  assign load         = !valid_r || !out_stall;
  assign is_last      = (idx_r == job_nbytes - NB_W'(1));

  always_comb begin
    q_pop     = 1'b0;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !q_status.empty;
      if (!q_status.empty) begin
        byte_nxt = BYTE_W'(job_acc >> {idx_r, 3'b000});
        last_nxt = is_last;
        q_pop    = is_last;
        idx_nxt  = is_last ? '0 : idx_r + NB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/code_symbol_bit_packer.sv =====
// ----------------------------------------------------------------------------
// code_symbol_bit_packer
// Packs (code, symbol) pairs LSB first into bytes; flush emits the partial
// byte zero padded.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    command, code, symbol, code_length
// out      output     out_valid/out_stall  out_byte, last
//
// A pair yields one to three bytes (default widths), one per cycle from the
// back end output register unless out_stall; a flush yields zero or one byte.
// The front end takes a request every cycle while the two-entry job queue
// has room.
// Reset is synchronous active low and clears pending bits, queue and output valid.
// out_stall holds the output register; the queue then fills and raises
// in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module code_symbol_bit_packer
  import csbp_pkg::*;
#(
  parameter int CODE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_command,
  input  wire logic [CODE_WIDTH-1:0]   in_code,
  input  wire logic [SYMBOL_WIDTH-1:0] in_symbol,
  input  wire logic [4:0]              in_code_length,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [BYTE_W-1:0]            out_out_byte,
  output logic                         out_last
);

  localparam int ACC_W = PEND_W + CODE_WIDTH + SYMBOL_WIDTH;
  localparam int NB_W  = $clog2(ACC_W / BYTE_W + 1);
  localparam int JOB_W = ACC_W + NB_W;

  logic             q_push;
  logic             q_pop;
  q_status_t        q_status;
  logic [ACC_W-1:0] push_acc;
  logic [NB_W-1:0]  push_nbytes;
  logic [JOB_W-1:0] head_job;

  csbp_front #(
    .CODE_WIDTH (CODE_WIDTH),
    .ACC_W      (ACC_W),
    .NB_W       (NB_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_code        (in_code),
    .in_symbol      (in_symbol),
    .in_code_length (in_code_length),
    .q_full         (q_status.full),
    .q_push         (q_push),
    .job_acc        (push_acc),
    .job_nbytes     (push_nbytes)
  );

  csbp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({push_nbytes, push_acc}),
    .pop     (q_pop),
    .rd_data (head_job),
    .status  (q_status)
  );

  csbp_back #(
    .ACC_W (ACC_W),
    .NB_W  (NB_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_acc      (head_job[ACC_W-1:0]),
    .job_nbytes   (head_job[JOB_W-1:ACC_W]),
    .q_status     (q_status),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

  `ASSERT_CLK(a_no_push_when_full, clk, rst_n, q_push |-> !q_status.full)
  `ASSERT_CLK(a_pop_shows_last, clk, rst_n, q_pop |=> (out_valid && out_last))
  `ASSERT_CLK(a_count_hold, clk, rst_n, (!q_push && !q_pop) |=> $stable(q_status.count))

endmodule

`default_nettype wire

// ===== tb/sv/code_symbol_bit_packer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_symbol_bit_packer_test
// Drives (code, symbol) pairs and flushes into the packer with random gaps
// on both channels. A scoreboard tracks the partial byte on its own, expects
// the packed bytes LSB first and checks each byte and its last flag in order.
// ----------------------------------------------------------------------------

class packer_scoreboard;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  packed_byte_t expected_bytes[$];
  logic [6:0]   held_bits;
  logic [2:0]   held_count;
  int           errors;

  function new();
    held_bits  = '0;
    held_count = '0;
    errors     = 0;
  endfunction

  function int outstanding();
    return expected_bytes.size();
  endfunction

  task report_mismatch(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function void note_request(csbp_pkg::cmd_t cmd, logic [15:0] code,
                             logic [7:0] symbol, logic [4:0] code_length);
    packed_byte_t  entry;
    logic [31:0]   stream;
    int unsigned   len;
    int unsigned   total;
    if (cmd == csbp_pkg::CMD_FLUSH) begin
      if (held_count != 0) begin
        entry.data = {1'b0, held_bits};
        entry.last = 1'b1;
        expected_bytes.push_back(entry);
      end
      held_bits  = '0;
      held_count = '0;
      return;
    end
    len    = (code_length > 16) ? 16 : code_length;
    stream = {25'b0, held_bits};
    stream |= ({16'b0, code} & ((32'h1 << len) - 32'h1)) << held_count;
    stream |= {24'b0, symbol} << (held_count + len);
    total  = held_count + len + csbp_pkg::SYMBOL_WIDTH;
    while (total >= 8) begin
      total -= 8;
      entry.data = stream[7:0];
      entry.last = (total < 8);
      expected_bytes.push_back(entry);
      stream = stream >> 8;
    end
    held_count = total[2:0];
    held_bits  = stream[6:0];
  endfunction

  task check_result(logic [7:0] data, logic last);
    packed_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
      return;
    end
    want = expected_bytes.pop_front();
    if (data !== want.data)
      report_mismatch($sformatf("byte %02h, want %02h", data, want.data));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b on byte %02h", last, want.last,
                                want.data));
  endtask

endclass

module code_symbol_bit_packer_test;
  import csbp_pkg::*;

  localparam int CODE_W       = 16;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 390;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  cmd_t                    in_command;
  logic [CODE_W-1:0]       in_code;
  logic [SYMBOL_WIDTH-1:0] in_symbol;
  logic [4:0]              in_code_length;
  logic                    out_valid;
  logic                    out_stall;
  logic [BYTE_W-1:0]       out_out_byte;
  logic                    out_last;

  packer_scoreboard sb;
  bit               quiet;
  bit               long_hold_request;
  int               cycle_count = 0;

  code_symbol_bit_packer #(.CODE_WIDTH(CODE_W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_code        (in_code),
    .in_symbol      (in_symbol),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task send_request(cmd_t cmd, logic [15:0] code, logic [7:0] symbol,
                    logic [4:0] code_length);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_code        <= code;
    in_symbol      <= symbol;
    in_code_length <= code_length;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, code, symbol, code_length);
  endtask

  task send_pair(logic [15:0] code, logic [7:0] symbol, logic [4:0] code_length);
    send_request(CMD_PACK, code, symbol, code_length);
  endtask

  task send_flush();
    send_request(CMD_FLUSH, 16'($urandom), 8'($urandom), 5'($urandom));
  endtask

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_request) begin
        hold = LONG_HOLD;
        long_hold_request = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_out_byte, out_last);
    end
  end

  initial begin : request_source
    bit         is_flush;
    logic [4:0] len;
    sb                = new();
    quiet             = 1'b0;
    long_hold_request = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_PACK;
    in_code        <= '0;
    in_symbol      <= '0;
    in_code_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty code, full-length code, clamped lengths, flush with and without bits
    send_pair(16'hFFFF, 8'hFF, 5'd0);
    send_pair(16'hFFFF, 8'h00, 5'd16);
    send_flush();
    send_pair(16'h0005, 8'hA5, 5'd3);
    send_flush();
    send_flush();
    send_pair(16'hFFFF, 8'h5A, 5'd17);
    send_pair(16'hFFFF, 8'hC3, 5'd31);
    send_pair(16'h0000, 8'h00, 5'd16);
    send_pair(16'h007F, 8'h81, 5'd7);
    send_pair(16'hABCD, 8'hFF, 5'd16);
    send_pair(16'h0001, 8'h7E, 5'd1);
    send_pair(16'h8001, 8'h01, 5'd16);
    send_pair(16'h0003, 8'h80, 5'd2);
    send_pair(16'h1234, 8'h00, 5'd24);
    send_flush();
    send_pair(16'h0000, 8'hFF, 5'd15);
    send_pair(16'h5555, 8'hAA, 5'd8);
    send_flush();
    send_pair(16'hFFFF, 8'hFF, 5'd16);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 120 && i < 200);
      if (i == 220 || i == 320)
        long_hold_request = 1'b1;
      is_flush = ($urandom_range(0, 7) == 0);
      len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
      if (is_flush)
        send_flush();
      else
        send_pair(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), len);
    end
    send_flush();
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/csbp_pkg.sv
design/csbp_front.sv
design/csbp_queue.sv
design/csbp_back.sv
design/code_symbol_bit_packer.sv
tb/sv/code_symbol_bit_packer_test.sv
